// File: rtl/rabin_karp_stream_matcher_core_assert.svh
// assertion macros shared by the rolling hash matcher rtl
// no dependencies; the empty forms apply when SYNTHESIS is defined
`ifndef RABIN_KARP_STREAM_MATCHER_CORE_ASSERT_SVH
`define RABIN_KARP_STREAM_MATCHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle as the trigger
`define RKSM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rksm assertion failed");

// condition holds in the cycle after the trigger
`define RKSM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rksm assertion failed");

`else

`define RKSM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RKSM_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/rksm_pkg.sv
// shared constants, types and the control store of the rolling hash matcher
// no dependencies; used by the mulmod, sequencer and top rtl files
package rksm_pkg;

  // widths and sizes
  localparam int HASH_W      = 30;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 16;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int MAX_PATTERN = 64;
  localparam int PTR_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int PC_W        = 5;
  localparam int CNT_W       = 5;
  localparam int NB_WIDE     = HASH_W;
  localparam int NB_BYTE     = BYTE_W;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DATA_W  = 24;

  localparam logic [HASH_W-1:0] BASE_RESET    = 30'd347;
  localparam logic [HASH_W-1:0] MODULUS_RESET = 30'd1000000007;
  localparam logic [POS_W-1:0]  POS_MAX       = 16'hFFFF;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PATTERN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_MODULUS = 2'd1;

  // micro-operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
  localparam logic [OP_W-1:0] OP_MUL      = 5'd1;
  localparam logic [OP_W-1:0] OP_LD_BR    = 5'd2;
  localparam logic [OP_W-1:0] OP_LD_BT    = 5'd3;
  localparam logic [OP_W-1:0] OP_LD_HR    = 5'd4;
  localparam logic [OP_W-1:0] OP_LD_TR_TP = 5'd5;
  localparam logic [OP_W-1:0] OP_LD_TR_PH = 5'd6;
  localparam logic [OP_W-1:0] OP_ADD_PH   = 5'd7;
  localparam logic [OP_W-1:0] OP_SET_TP1  = 5'd8;
  localparam logic [OP_W-1:0] OP_TXT_PREP = 5'd9;
  localparam logic [OP_W-1:0] OP_SUB_OLD  = 5'd10;
  localparam logic [OP_W-1:0] OP_ADD_WH   = 5'd11;
  localparam logic [OP_W-1:0] OP_PAT_DONE = 5'd12;
  localparam logic [OP_W-1:0] OP_TXT_DONE = 5'd13;
  localparam logic [OP_W-1:0] OP_FULL     = 5'd14;
  localparam logic [OP_W-1:0] OP_NOPAT    = 5'd15;
  localparam logic [OP_W-1:0] OP_RESTART  = 5'd16;
  localparam logic [OP_W-1:0] OP_CLEAR    = 5'd17;

  // multiplier operand a (always below the modulus)
  localparam logic [1:0] A_ONE = 2'd0;
  localparam logic [1:0] A_BR  = 2'd1;
  localparam logic [1:0] A_TR  = 2'd2;

  // multiplier operand b (any value)
  localparam logic [2:0] B_BASE = 3'd0;
  localparam logic [2:0] B_BYTE = 3'd1;
  localparam logic [2:0] B_WH   = 3'd2;
  localparam logic [2:0] B_TP   = 3'd3;
  localparam logic [2:0] B_PH   = 3'd4;
  localparam logic [2:0] B_OB   = 3'd5;
  localparam logic [2:0] B_HR   = 3'd6;

  // multiplier destination
  localparam logic [2:0] D_BR = 3'd0;
  localparam logic [2:0] D_BT = 3'd1;
  localparam logic [2:0] D_HR = 3'd2;
  localparam logic [2:0] D_TR = 3'd3;
  localparam logic [2:0] D_TP = 3'd4;

  // jump conditions
  localparam logic [3:0] C_NEXT     = 4'd0;
  localparam logic [3:0] C_ALWAYS   = 4'd1;
  localparam logic [3:0] C_FULL     = 4'd2;
  localparam logic [3:0] C_LEN_ZERO = 4'd3;
  localparam logic [3:0] C_BASE_LT  = 4'd4;
  localparam logic [3:0] C_BYTE_LT  = 4'd5;
  localparam logic [3:0] C_WH_LT    = 4'd6;
  localparam logic [3:0] C_TP_LT    = 4'd7;
  localparam logic [3:0] C_PH_LT    = 4'd8;
  localparam logic [3:0] C_NOT_WIN  = 4'd9;

  // control store addresses
  localparam logic [PC_W-1:0] UA_PATTERN = 5'd0;
  localparam logic [PC_W-1:0] UA_P_BT    = 5'd3;
  localparam logic [PC_W-1:0] UA_P_MULH  = 5'd5;
  localparam logic [PC_W-1:0] UA_P_TP1   = 5'd8;
  localparam logic [PC_W-1:0] UA_P_DONE  = 5'd9;
  localparam logic [PC_W-1:0] UA_FULL    = 5'd10;
  localparam logic [PC_W-1:0] UA_NOPAT   = 5'd11;
  localparam logic [PC_W-1:0] UA_RESTART = 5'd12;
  localparam logic [PC_W-1:0] UA_CLEAR   = 5'd13;
  localparam logic [PC_W-1:0] UA_TEXT    = 5'd14;
  localparam logic [PC_W-1:0] UA_T_BT    = 5'd18;
  localparam logic [PC_W-1:0] UA_T_HR    = 5'd20;
  localparam logic [PC_W-1:0] UA_T_WIN   = 5'd22;
  localparam logic [PC_W-1:0] UA_T_OLD   = 5'd25;
  localparam logic [PC_W-1:0] UA_T_ROLL  = 5'd27;
  localparam logic [PC_W-1:0] UA_T_DONE  = 5'd31;

  // one control word
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      a_sel;
    logic [2:0]      b_sel;
    logic [2:0]      dst;
    logic [3:0]      cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ucw_t;

  // status flags the jumps test
  typedef struct packed {
    logic full;
    logic len_zero;
    logic base_lt;
    logic byte_lt;
    logic wh_lt;
    logic tp_lt;
    logic ph_lt;
    logic not_win;
  } cond_t;

  // request to the modular multiplier
  typedef struct packed {
    logic              start;
    logic              wide;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mul_req_t;

  function automatic ucw_t mk(input logic [OP_W-1:0] op, input logic [1:0] a_sel,
                              input logic [2:0] b_sel, input logic [2:0] dst,
                              input logic [3:0] cond, input logic [PC_W-1:0] target,
                              input logic last);
    ucw_t w;
    w.op     = op;
    w.a_sel  = a_sel;
    w.b_sel  = b_sel;
    w.dst    = dst;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // entry point of each request kind
  function automatic logic [PC_W-1:0] ucode_entry(input logic [REQ_W-1:0] req);
    logic [PC_W-1:0] e;
    unique case (req)
      REQ_PATTERN: e = UA_PATTERN;
      REQ_TEXT:    e = UA_TEXT;
      REQ_RESTART: e = UA_RESTART;
      REQ_CLEAR:   e = UA_CLEAR;
      default:     e = UA_CLEAR;
    endcase
    return e;
  endfunction

  // the microprogram; reductions are skipped when a value is already below the modulus
  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      // pattern byte
      5'd0:  w = mk(OP_NOP, A_ONE, B_BASE, D_BR, C_FULL, UA_FULL, 1'b0);
      5'd1:  w = mk(OP_LD_BR, A_ONE, B_BASE, D_BR, C_BASE_LT, UA_P_BT, 1'b0);
      5'd2:  w = mk(OP_MUL, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b0);
      5'd3:  w = mk(OP_LD_BT, A_ONE, B_BYTE, D_BT, C_BYTE_LT, UA_P_MULH, 1'b0);
      5'd4:  w = mk(OP_MUL, A_ONE, B_BYTE, D_BT, C_NEXT, UA_PATTERN, 1'b0);
      5'd5:  w = mk(OP_MUL, A_BR, B_PH, D_HR, C_NEXT, UA_PATTERN, 1'b0);
      5'd6:  w = mk(OP_ADD_PH, A_ONE, B_PH, D_HR, C_LEN_ZERO, UA_P_TP1, 1'b0);
      5'd7:  w = mk(OP_MUL, A_BR, B_TP, D_TP, C_ALWAYS, UA_P_DONE, 1'b0);
      5'd8:  w = mk(OP_SET_TP1, A_ONE, B_TP, D_TP, C_NEXT, UA_PATTERN, 1'b0);
      5'd9:  w = mk(OP_PAT_DONE, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b1);
      // single-step requests and refusals
      5'd10: w = mk(OP_FULL, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b1);
      5'd11: w = mk(OP_NOPAT, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b1);
      5'd12: w = mk(OP_RESTART, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b1);
      5'd13: w = mk(OP_CLEAR, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b1);
      // text byte
      5'd14: w = mk(OP_NOP, A_ONE, B_BASE, D_BR, C_LEN_ZERO, UA_NOPAT, 1'b0);
      5'd15: w = mk(OP_TXT_PREP, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b0);
      5'd16: w = mk(OP_LD_BR, A_ONE, B_BASE, D_BR, C_BASE_LT, UA_T_BT, 1'b0);
      5'd17: w = mk(OP_MUL, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b0);
      5'd18: w = mk(OP_LD_BT, A_ONE, B_BYTE, D_BT, C_BYTE_LT, UA_T_HR, 1'b0);
      5'd19: w = mk(OP_MUL, A_ONE, B_BYTE, D_BT, C_NEXT, UA_PATTERN, 1'b0);
      5'd20: w = mk(OP_LD_HR, A_ONE, B_WH, D_HR, C_WH_LT, UA_T_WIN, 1'b0);
      5'd21: w = mk(OP_MUL, A_ONE, B_WH, D_HR, C_NEXT, UA_PATTERN, 1'b0);
      5'd22: w = mk(OP_NOP, A_ONE, B_BASE, D_BR, C_NOT_WIN, UA_T_ROLL, 1'b0);
      5'd23: w = mk(OP_LD_TR_TP, A_ONE, B_TP, D_TR, C_TP_LT, UA_T_OLD, 1'b0);
      5'd24: w = mk(OP_MUL, A_ONE, B_TP, D_TR, C_NEXT, UA_PATTERN, 1'b0);
      5'd25: w = mk(OP_MUL, A_TR, B_OB, D_TR, C_NEXT, UA_PATTERN, 1'b0);
      5'd26: w = mk(OP_SUB_OLD, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b0);
      5'd27: w = mk(OP_MUL, A_BR, B_HR, D_HR, C_NEXT, UA_PATTERN, 1'b0);
      5'd28: w = mk(OP_ADD_WH, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b0);
      5'd29: w = mk(OP_LD_TR_PH, A_ONE, B_PH, D_TR, C_PH_LT, UA_T_DONE, 1'b0);
      5'd30: w = mk(OP_MUL, A_ONE, B_PH, D_TR, C_NEXT, UA_PATTERN, 1'b0);
      5'd31: w = mk(OP_TXT_DONE, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b1);
      default: w = mk(OP_CLEAR, A_ONE, B_BASE, D_BR, C_NEXT, UA_PATTERN, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// File: rtl/rksm_ram.sv
// generic single-port-write ram with one registered read port
// no dependencies
module rksm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rksm_mulmod.sv
// bit-serial modular multiplier: a * b mod m, one bit of b per cycle, msb first
// depends on rksm_pkg; operand a must already be below m, m must be nonzero
module rksm_mulmod (
  input  logic                             clk,
  input  logic                             rst,
  input  rksm_pkg::mul_req_t               req,
  input  logic [rksm_pkg::HASH_W-1:0]      m,
  output logic                             done,
  output logic [rksm_pkg::HASH_W-1:0]      res
);

  localparam int W  = rksm_pkg::HASH_W;
  localparam int BW = rksm_pkg::BYTE_W;

  logic [W-1:0]                 r;
  logic [W-1:0]                 a_q;
  logic [W-1:0]                 b_q;
  logic [rksm_pkg::CNT_W-1:0]   cnt;
  logic                         run;
  logic [W+1:0]                 t0;
  logic [W+1:0]                 t1;
  logic [W+1:0]                 t2;
  logic [W+1:0]                 m_x;
  logic [W-1:0]                 r_next;

  // double, add a on a set bit, then bring back below m (sum is under 3m)
  always_comb begin
    m_x    = {2'b00, m};
    t0     = {1'b0, r, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
    t1     = (t0 >= m_x) ? t0 - m_x : t0;
    t2     = (t1 >= m_x) ? t1 - m_x : t1;
    r_next = t2[W-1:0];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == rksm_pkg::CNT_W'(1));
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.wide ? rksm_pkg::CNT_W'(rksm_pkg::NB_WIDE)
                        : rksm_pkg::CNT_W'(rksm_pkg::NB_BYTE);
      end else if (run) begin
        cnt <= cnt - rksm_pkg::CNT_W'(1);
        if (cnt == rksm_pkg::CNT_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      r   <= '0;
      a_q <= req.a;
      b_q <= req.wide ? req.b : {req.b[BW-1:0], {(W-BW){1'b0}}};
    end else if (run) begin
      r   <= r_next;
      b_q <= {b_q[W-2:0], 1'b0};
    end
  end

  assign res = r;

endmodule

// File: rtl/rksm_sequencer.sv
// microprogram sequencer: step counter, control store lookup and conditional jumps
// depends on rksm_pkg and rabin_karp_stream_matcher_core_assert.svh
`include "rabin_karp_stream_matcher_core_assert.svh"

module rksm_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rksm_pkg::PC_W-1:0]     entry,
  input  rksm_pkg::cond_t               cond,
  input  logic                          mul_done,
  input  logic                          out_free,
  output rksm_pkg::ucw_t                uw,
  output logic                          fire,
  output logic                          mul_start,
  output logic                          active
);

  logic [rksm_pkg::PC_W-1:0] pc;
  logic                      mul_wait;
  logic                      take;
  logic                      is_mul;

  assign uw     = rksm_pkg::ucode_rom(pc);
  assign is_mul = (uw.op == rksm_pkg::OP_MUL);

  // jump condition of the current word
  always_comb begin
    unique case (uw.cond)
      rksm_pkg::C_NEXT:     take = 1'b0;
      rksm_pkg::C_ALWAYS:   take = 1'b1;
      rksm_pkg::C_FULL:     take = cond.full;
      rksm_pkg::C_LEN_ZERO: take = cond.len_zero;
      rksm_pkg::C_BASE_LT:  take = cond.base_lt;
      rksm_pkg::C_BYTE_LT:  take = cond.byte_lt;
      rksm_pkg::C_WH_LT:    take = cond.wh_lt;
      rksm_pkg::C_TP_LT:    take = cond.tp_lt;
      rksm_pkg::C_PH_LT:    take = cond.ph_lt;
      rksm_pkg::C_NOT_WIN:  take = cond.not_win;
      default:              take = 1'b0;
    endcase
  end

  // a multiply word completes with the multiplier; a final word waits for the output slot
  assign mul_start = active && is_mul && !mul_wait;
  assign fire      = active && (is_mul ? (mul_wait && mul_done) : (!uw.last || out_free));

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      pc       <= rksm_pkg::UA_PATTERN;
      mul_wait <= 1'b0;
    end else if (start) begin
      active   <= 1'b1;
      pc       <= entry;
      mul_wait <= 1'b0;
    end else if (active) begin
      if (mul_start) begin
        mul_wait <= 1'b1;
      end
      if (fire) begin
        mul_wait <= 1'b0;
        pc       <= take ? uw.target : pc + rksm_pkg::PC_W'(1);
        if (uw.last) begin
          active <= 1'b0;
        end
      end
    end
  end

  // checks
  `RKSM_ASSERT_NXT(a_start_runs, clk, rst, start, active)
  `RKSM_ASSERT_IMP(a_wait_on_mul, clk, rst, mul_wait, active && is_mul)
  `RKSM_ASSERT_NXT(a_mul_waits, clk, rst, mul_start, mul_wait)
  `RKSM_ASSERT_IMP(a_end_has_slot, clk, rst, fire && uw.last, out_free)

endmodule

// File: rtl/rabin_karp_stream_matcher_core.sv
// rolling hash (rabin-karp) stream matcher top; uses rksm_pkg, sequencer, mulmod and ram
// result timing depends on the request: later pattern bytes and text bytes once the window
// is full add multiplies, and base, byte or stored hashes that need reducing add more; a
// 30-bit multiply runs longer than a byte one
// one request in flight: ready rises with result valid; a stalled result delays the next
// synchronous active-high reset: base 347, modulus 1000000007, empty pattern, store uncleared
module rabin_karp_stream_matcher_core (
  input  logic                                clk,
  input  logic                                rst,
  // request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] data_byte
  input  logic [rksm_pkg::REQ_W-1:0]          s_tuser,  // [1:0] req_type
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rksm_pkg::OUT_DATA_W-1:0]     m_tdata,  // [0] matched, [16:1] match_start
  output logic [rksm_pkg::STATUS_W-1:0]       m_tuser,  // [1:0] status
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rksm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rksm_pkg::HASH_W-1:0]         cfg_data
);

  localparam int W     = rksm_pkg::HASH_W;
  localparam int BW    = rksm_pkg::BYTE_W;
  localparam int PW    = rksm_pkg::POS_W;
  localparam int LW    = rksm_pkg::LEN_W;
  localparam int TW    = rksm_pkg::PTR_W;

  // configuration and architectural state
  logic [W-1:0]  hash_base;
  logic [W-1:0]  hash_modulus;
  logic [LW-1:0] pattern_length;
  logic [W-1:0]  pattern_hash;
  logic [W-1:0]  top_power;
  logic [W-1:0]  window_hash;
  logic [PW-1:0] text_position;
  logic [TW-1:0] window_pointer;

  // working registers
  logic [BW-1:0] byte_q;
  logic [W-1:0]  br;
  logic [BW-1:0] bt;
  logic [W-1:0]  hr;
  logic [W-1:0]  tr;
  logic [BW-1:0] ob;

  // result register
  logic          out_matched;
  logic [PW-1:0] out_start;
  logic [rksm_pkg::STATUS_W-1:0] out_status;

  // sequencer and multiplier links
  rksm_pkg::ucw_t     uw;
  rksm_pkg::cond_t    cond;
  rksm_pkg::mul_req_t mreq;
  logic               fire;
  logic               mul_start;
  logic               mul_done;
  logic [W-1:0]       mul_res;
  logic               active;
  logic               accept;
  logic               out_free;
  logic               mul_wr;
  logic               ram_we;

  // datapath values
  logic [W-1:0]  m_eff;
  logic [W-1:0]  one_m;
  logic [W:0]    sum_hb;
  logic [W-1:0]  sum_red;
  logic [W-1:0]  sub_old;
  logic [PW:0]   pos_inc;
  logic [LW-1:0] ptr_inc;
  logic [TW-1:0] ptr_prep;
  logic [TW-1:0] ptr_adv;
  logic          win_full;
  logic          res_matched;
  logic [PW-1:0] res_start;
  logic [rksm_pkg::STATUS_W-1:0] res_status;

  // handshakes
  assign s_tready  = !active;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign mul_wr    = fire && (uw.op == rksm_pkg::OP_MUL);
  assign ram_we    = fire && (uw.op == rksm_pkg::OP_ADD_WH);

  // modulus zero acts as one; "one" reduced by the modulus
  assign m_eff = (hash_modulus == '0) ? W'(1) : hash_modulus;
  assign one_m = (m_eff == W'(1)) ? '0 : W'(1);

  // flags for the jumps
  always_comb begin
    cond.full     = pattern_length >= LW'(rksm_pkg::MAX_PATTERN);
    cond.len_zero = pattern_length == '0;
    cond.base_lt  = hash_base < m_eff;
    cond.byte_lt  = W'(byte_q) < m_eff;
    cond.wh_lt    = window_hash < m_eff;
    cond.tp_lt    = top_power < m_eff;
    cond.ph_lt    = pattern_hash < m_eff;
    cond.not_win  = text_position < PW'(pattern_length);
  end

  // multiplier operands
  always_comb begin
    mreq.start = mul_start;
    unique case (uw.a_sel)
      rksm_pkg::A_ONE: mreq.a = one_m;
      rksm_pkg::A_BR:  mreq.a = br;
      rksm_pkg::A_TR:  mreq.a = tr;
      default:         mreq.a = one_m;
    endcase
    unique case (uw.b_sel)
      rksm_pkg::B_BASE: mreq.b = hash_base;
      rksm_pkg::B_BYTE: mreq.b = W'(byte_q);
      rksm_pkg::B_WH:   mreq.b = window_hash;
      rksm_pkg::B_TP:   mreq.b = top_power;
      rksm_pkg::B_PH:   mreq.b = pattern_hash;
      rksm_pkg::B_OB:   mreq.b = W'(ob);
      rksm_pkg::B_HR:   mreq.b = hr;
      default:          mreq.b = hash_base;
    endcase
    mreq.wide = !((uw.b_sel == rksm_pkg::B_BYTE) || (uw.b_sel == rksm_pkg::B_OB));
  end

  // combinational arithmetic: add the reduced byte, remove the oldest term, window moves
  always_comb begin
    sum_hb   = {1'b0, hr} + (W + 1)'(bt);
    sum_red  = (sum_hb >= {1'b0, m_eff}) ? W'(sum_hb - {1'b0, m_eff}) : sum_hb[W-1:0];
    sub_old  = (hr >= tr) ? hr - tr : W'({1'b0, hr} + {1'b0, m_eff} - {1'b0, tr});
    pos_inc  = {1'b0, text_position} + (PW + 1)'(1);
    ptr_inc  = LW'(window_pointer) + LW'(1);
    ptr_prep = (LW'(window_pointer) >= pattern_length) ? '0 : window_pointer;
    ptr_adv  = (ptr_inc >= pattern_length) ? '0 : ptr_inc[TW-1:0];
    win_full = pos_inc >= (PW + 1)'(pattern_length);
  end

  // result of the final word
  always_comb begin
    res_matched = 1'b0;
    res_start   = '0;
    res_status  = rksm_pkg::ST_OK;
    unique case (uw.op)
      rksm_pkg::OP_TXT_DONE: begin
        res_matched = win_full && (window_hash == tr);
        if (res_matched) begin
          res_start = (text_position == rksm_pkg::POS_MAX) ? rksm_pkg::POS_MAX
                    : PW'(pos_inc - (PW + 1)'(pattern_length));
        end
      end
      rksm_pkg::OP_FULL:  res_status = rksm_pkg::ST_PAT_FULL;
      rksm_pkg::OP_NOPAT: res_status = rksm_pkg::ST_NO_PATTERN;
      default:            res_status = rksm_pkg::ST_OK;
    endcase
  end

  // configuration, hash state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_base      <= rksm_pkg::BASE_RESET;
      hash_modulus   <= rksm_pkg::MODULUS_RESET;
      pattern_length <= '0;
      pattern_hash   <= '0;
      top_power      <= W'(1);
      window_hash    <= '0;
      text_position  <= '0;
      window_pointer <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rksm_pkg::REG_HASH_BASE) begin
          hash_base <= cfg_data;
        end else if (cfg_index == rksm_pkg::REG_HASH_MODULUS) begin
          hash_modulus <= cfg_data;
        end
      end
      if (mul_wr && (uw.dst == rksm_pkg::D_TP)) begin
        top_power <= mul_res;
      end
      if (fire) begin
        unique case (uw.op)
          rksm_pkg::OP_ADD_PH:   pattern_hash <= sum_red;
          rksm_pkg::OP_SET_TP1:  top_power <= one_m;
          rksm_pkg::OP_TXT_PREP: window_pointer <= ptr_prep;
          rksm_pkg::OP_ADD_WH:   window_hash <= sum_red;
          rksm_pkg::OP_PAT_DONE: begin
            pattern_length <= pattern_length + LW'(1);
            window_hash    <= '0;
            text_position  <= '0;
            window_pointer <= '0;
          end
          rksm_pkg::OP_TXT_DONE: begin
            window_pointer <= ptr_adv;
            if (text_position != rksm_pkg::POS_MAX) begin
              text_position <= pos_inc[PW-1:0];
            end
          end
          rksm_pkg::OP_RESTART: begin
            window_hash    <= '0;
            text_position  <= '0;
            window_pointer <= '0;
          end
          rksm_pkg::OP_CLEAR: begin
            pattern_length <= '0;
            pattern_hash   <= '0;
            top_power      <= W'(1);
            window_hash    <= '0;
            text_position  <= '0;
            window_pointer <= '0;
          end
          default: begin
          end
        endcase
      end
      if (fire && uw.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= s_tdata[BW-1:0];
    end
    if (mul_wr) begin
      unique case (uw.dst)
        rksm_pkg::D_BR: br <= mul_res;
        rksm_pkg::D_BT: bt <= mul_res[BW-1:0];
        rksm_pkg::D_HR: hr <= mul_res;
        rksm_pkg::D_TR: tr <= mul_res;
        default: begin
        end
      endcase
    end
    if (fire) begin
      unique case (uw.op)
        rksm_pkg::OP_LD_BR:    br <= hash_base;
        rksm_pkg::OP_LD_BT:    bt <= byte_q;
        rksm_pkg::OP_LD_HR:    hr <= window_hash;
        rksm_pkg::OP_LD_TR_TP: tr <= top_power;
        rksm_pkg::OP_LD_TR_PH: tr <= pattern_hash;
        rksm_pkg::OP_SUB_OLD:  hr <= sub_old;
        default: begin
        end
      endcase
    end
    if (fire && uw.last) begin
      out_matched <= res_matched;
      out_start   <= res_start;
      out_status  <= res_status;
    end
  end

  assign m_tdata = {{(rksm_pkg::OUT_DATA_W - PW - 1){1'b0}}, out_start, out_matched};
  assign m_tuser = out_status;

  // control sequencer
  rksm_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .entry     (rksm_pkg::ucode_entry(s_tuser)),
    .cond      (cond),
    .mul_done  (mul_done),
    .out_free  (out_free),
    .uw        (uw),
    .fire      (fire),
    .mul_start (mul_start),
    .active    (active)
  );

  // shared modular multiplier
  rksm_mulmod u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .m    (m_eff),
    .done (mul_done),
    .res  (mul_res)
  );

  // window store
  rksm_ram #(
    .WIDTH (rksm_pkg::BYTE_W),
    .DEPTH (rksm_pkg::MAX_PATTERN)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (window_pointer),
    .wdata (byte_q),
    .raddr (window_pointer),
    .rdata (ob)
  );

endmodule
